FILE: rtl/core/ed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_pkg
// Types and constants shared by the Euclidean distance controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam int unsigned ElemW   = 32;
  localparam int unsigned TypeW   = 2;
  localparam int unsigned ProdW   = 2 * ElemW;
  localparam int unsigned AccW    = 76;
  localparam int unsigned RootW   = AccW / 2;
  localparam int unsigned RemW    = RootW + 2;
  localparam int unsigned StepW   = $clog2(RootW);

  // Element type register codes.
  typedef enum logic [TypeW-1:0] {
    TYPE_INT8  = 2'd0,
    TYPE_INT16 = 2'd1,
    TYPE_INT32 = 2'd2,
    TYPE_NONE  = 2'd3
  } elem_type_e;

  localparam elem_type_e TypeReset = TYPE_INT32;

  typedef struct packed {
    logic signed [ElemW-1:0] elem_a;
    logic signed [ElemW-1:0] elem_b;
    logic                    last;
  } in_item_t;

  typedef struct packed {
    logic [RootW-1:0] distance;
    logic             error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_STREAM,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } ctrl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic take;       // load the pair into the first stage
    logic add;        // this pair contributes to the sum
    logic root_init;  // clear the root and remainder, latch the error flag
    logic root_step;  // one digit of the square root
    logic out_load;   // move the finished result into the output register
  } ed_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic type_ok;    // element type register holds a supported format
    logic last_done;  // the last pair is in the accumulator stage this cycle
    logic out_free;   // the output register can take a result
  } ed_stat_t;

endpackage

FILE: rtl/core/ed_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_ctrl
// Sequencer for the distance block: streams pairs, drains the pipeline on
// the last pair, steps the square root and hands the result out.
// ----------------------------------------------------------------------------
module ed_ctrl #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  ed_pkg::ed_stat_t stat_i,
  output ed_pkg::ed_cmd_t  cmd_o
);
  import ed_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DIM + 1);

  ctrl_state_e      state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [StepW-1:0] step_q, step_d;
  logic             step_last;

  assign step_last = (step_q == StepW'(RootW - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_STREAM;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    step_d         = step_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_STREAM: begin
        in_ready_o = 1'b1;
        cmd_o.add  = stat_i.type_ok && (cnt_q < CntW'(MAX_DIM));
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_last_i) begin
            cnt_d   = '0;
            state_d = ST_DRAIN;
          end else if (cmd_o.add) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // Wait for the last pair to reach the accumulator.
        if (stat_i.last_done) begin
          cmd_o.root_init = 1'b1;
          step_d          = '0;
          state_d         = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_last) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_STREAM;
        end
      end
      default: begin
        state_d = ST_STREAM;
      end
    endcase
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_DIM))
    else $error("pair count passed its limit");

  a_root_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT && step_last) |=> (state_q == ST_OUT))
    else $error("square root did not finish after its last digit");

  a_cnt_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROOT) |-> (cnt_q == '0))
    else $error("pair count not cleared after the last item");

endmodule

FILE: rtl/core/ed_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ed_datapath
// Element format register, difference and square pipeline, 76-bit
// accumulator, digit-by-digit square root and output register.
// ----------------------------------------------------------------------------
module ed_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_wdata_i,
  input  ed_pkg::in_item_t     in_item_i,
  input  ed_pkg::ed_cmd_t      cmd_i,
  output ed_pkg::ed_stat_t     stat_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ed_pkg::out_item_t    out_item_o
);
  import ed_pkg::*;

  elem_type_e          type_q;

  // First stage: absolute difference.
  logic                a_valid_q, a_last_q, a_add_q, a_err_q;
  logic [ElemW-1:0]    a_abs_q;
  logic signed [ElemW:0] ext_a, ext_b, diff;
  logic [ElemW:0]      abs_d;

  // Second stage: square.
  logic                b_valid_q, b_last_q, b_add_q, b_err_q;
  logic [ProdW-1:0]    b_prod_q, prod_d;

  logic [AccW-1:0]     acc_q;
  logic [RootW-1:0]    root_q;
  logic [RemW-1:0]     rem_q;
  logic [RemW+1:0]     rem_sh, trial;
  logic                err_q;

  logic                out_valid_q;
  out_item_t           out_item_q;

  always_comb begin
    case (type_q)
      TYPE_INT8: begin
        ext_a = (ElemW+1)'($signed(in_item_i.elem_a[7:0]));
        ext_b = (ElemW+1)'($signed(in_item_i.elem_b[7:0]));
      end
      TYPE_INT16: begin
        ext_a = (ElemW+1)'($signed(in_item_i.elem_a[15:0]));
        ext_b = (ElemW+1)'($signed(in_item_i.elem_b[15:0]));
      end
      default: begin
        ext_a = (ElemW+1)'(in_item_i.elem_a);
        ext_b = (ElemW+1)'(in_item_i.elem_b);
      end
    endcase
    diff  = ext_a - ext_b;
    abs_d = diff[ElemW] ? ((ElemW+1)'(0) - diff) : diff;
  end

  assign prod_d = ProdW'(a_abs_q) * ProdW'(a_abs_q);

  // One root digit: bring down two radicand bits and try (root << 2) | 1.
  assign rem_sh = {rem_q, acc_q[AccW-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q      <= TypeReset;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        type_q <= elem_type_e'(cfg_wdata_i);
      end
      a_valid_q <= cmd_i.take;
      b_valid_q <= a_valid_q;
      if (b_valid_q && b_add_q) begin
        acc_q <= acc_q + AccW'(b_prod_q);
      end else if (cmd_i.root_step) begin
        // The radicand shifts out as the root is built, leaving zero.
        acc_q <= {acc_q[AccW-3:0], 2'b00};
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      a_abs_q  <= abs_d[ElemW-1:0];
      a_last_q <= in_item_i.last;
      a_add_q  <= cmd_i.add;
      a_err_q  <= (type_q == TYPE_NONE);
    end
    b_prod_q <= prod_d;
    b_last_q <= a_last_q;
    b_add_q  <= a_add_q;
    b_err_q  <= a_err_q;
    if (cmd_i.root_init) begin
      root_q <= '0;
      rem_q  <= '0;
      err_q  <= b_err_q;
    end else if (cmd_i.root_step) begin
      if (rem_sh >= trial) begin
        rem_q  <= RemW'(rem_sh - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[RemW-1:0];
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_item_q.distance <= err_q ? '0 : root_q;
      out_item_q.error    <= err_q;
    end
  end

  assign stat_o.type_ok   = (type_q != TYPE_NONE);
  assign stat_o.last_done = b_valid_q && b_last_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_acc_cleared : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (acc_q == '0))
    else $error("accumulator not empty when the result is loaded");

  a_pipe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.root_step |-> (!a_valid_q && !b_valid_q))
    else $error("pair still in flight during the square root");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !out_ready_i))
    else $error("result loaded over one not yet taken");

endmodule

FILE: rtl/core/euclidean_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euclidean_distance
// Streaming L2 distance between two signed integer vectors.
// ----------------------------------------------------------------------------
// Each input item carries one element pair and a last flag; pairs are taken one
// per cycle and their squared differences summed exactly in a 76-bit
// accumulator, up to MAX_DIM pairs per vector (further pairs add nothing). The
// item marked last closes the vector: input ready then drops while the
// difference and square stages drain, the digit-by-digit square root builds
// its 38-bit result (one result bit per cycle) and the output register is
// loaded once the previous result has been taken. The
// result item carries the floor square root of the sum, or zero with the error
// flag set if the element type register held the unsupported code when the
// last item arrived. The element type register (0 int8, 1 int16, 2 int32 at
// reset) should only be written while no vector is in progress.
module euclidean_distance #(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ed_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ed_pkg::out_item_t out_item_o
);
  import ed_pkg::*;

  ed_cmd_t  cmd;
  ed_stat_t stat;

  ed_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ed_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
